// ===== rtl/eps_pkg.sv =====
// ----------------------------------------------------------------------------
// eps_pkg
// Shared widths, register indexes, reset values and controller/datapath
// command and status types of the expression pedal scaler.
// ----------------------------------------------------------------------------
package eps_pkg;

	localparam int SAMPLE_BITS_DEF = 10;

	localparam int RANGE_W   = 10;
	localparam int SCALE_W   = 6;
	localparam int CHAN_W    = 4;
	localparam int CCNUM_W   = 7;
	localparam int OUTCH_W   = 5;
	localparam int PROD_W    = RANGE_W + SCALE_W;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = RANGE_W;

	// Output tdata: cc_number, cc_value, channel, padded to whole bytes.
	localparam int OUT_FIELDS_W = CCNUM_W + SCALE_W + OUTCH_W;
	localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

	// Register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_RANGE_LOW   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RANGE_HIGH  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SCALE_TOP   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DEADBAND    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MIDI_CHAN   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_CC_NUMBER   = 3'd5;

	// Reset values.
	localparam logic [RANGE_W-1:0] RST_RANGE_LOW  = 10'd0;
	localparam logic [RANGE_W-1:0] RST_RANGE_HIGH = 10'd1023;
	localparam logic [SCALE_W-1:0] RST_SCALE_TOP  = 6'd31;
	localparam logic [SCALE_W-1:0] RST_DEADBAND   = 6'd1;
	localparam logic [CHAN_W-1:0]  RST_MIDI_CHAN  = 4'd0;
	localparam logic [CCNUM_W-1:0] RST_CC_NUMBER  = 7'd0;

	typedef struct packed {
		logic capture;
		logic mul;
		logic div_start;
		logic decide;
		logic emit;
	} eps_cmd_t;

	typedef struct packed {
		logic div_done;
		logic skip;
		logic out_free;
		logic at_target;
	} eps_sts_t;

endpackage

// ===== rtl/expression_pedal_scaler.sv =====
// ----------------------------------------------------------------------------
// expression_pedal_scaler
// Scales pedal converter samples into stepped controller messages.
// ----------------------------------------------------------------------------
// Each accepted sample is clamped to range_low..range_high and scaled to
// 0..scale_top as floor((clamped - range_low) * scale_top / (range_high -
// range_low)), or 0 when the window is empty. When the scaled value moved by
// at least deadband from the last sent value, the block sends a run of
// controller messages stepping one unit at a time toward the new value, with
// tlast on the final message; the first send after reset is a single message.
// Steps: a sample passes a capture step, a multiply step, a divider load step
// and the bit-serial restoring divider, then a decision step, followed by one
// message of the run per cycle (0 to 63 messages) while the output side does
// not stall. The next sample is taken as soon as the last message of the run
// has been loaded into the output register. Configuration registers must be
// written by the user only while the block is idle; the block itself does
// not enforce this.
// ----------------------------------------------------------------------------
module expression_pedal_scaler #(
	parameter int SAMPLE_BITS = eps_pkg::SAMPLE_BITS_DEF,
	localparam int IN_TDATA_W = ((SAMPLE_BITS + 7) / 8) * 8
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// Configuration write port.
	input  logic                            cfg_wen,
	input  logic [eps_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [eps_pkg::CFG_DATA_W-1:0]  cfg_data,
	// Sample stream.
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [IN_TDATA_W-1:0]           s_tdata,   // sample
	// Controller message stream.
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [eps_pkg::OUT_TDATA_W-1:0] m_tdata,   // cc_number, cc_value, channel
	output logic                            m_tlast    // last_of_run
);
	import eps_pkg::*;

	eps_cmd_t cmd;
	eps_sts_t sts;

	// The controller owns sequencing; the datapath owns every value.
	eps_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.sts     (sts),
		.cmd     (cmd)
	);

	eps_datapath #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wen  (cfg_wen),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.sample   (s_tdata[SAMPLE_BITS-1:0]),
		.cmd      (cmd),
		.sts      (sts),
		.m_tready (m_tready),
		.m_tvalid (m_tvalid),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule

// ===== rtl/eps_div.sv =====
// ----------------------------------------------------------------------------
// eps_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module eps_div #(
	parameter int DIVIDEND_W = 16,
	parameter int DIVISOR_W  = 10
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [DIVIDEND_W-1:0] dividend,
	input  logic [DIVISOR_W-1:0]  divisor,
	output logic                  done,
	output logic [DIVIDEND_W-1:0] quotient
);

	localparam int CNT_W = (DIVIDEND_W > 1) ? $clog2(DIVIDEND_W) : 1;
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIVIDEND_W - 1);

	logic                  busy_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [DIVISOR_W-1:0]  dsr_q;
	logic [DIVISOR_W-1:0]  rem_q;
	logic [DIVIDEND_W-1:0] quo_q;
	logic [DIVISOR_W:0]    trial;
	logic                  fits;

	assign trial = {rem_q, quo_q[DIVIDEND_W-1]};
	assign fits  = (trial >= {1'b0, dsr_q});
	assign done  = busy_q && (cnt_q == CNT_LAST);
	assign quotient = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CNT_LAST) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dsr_q <= divisor;
			rem_q <= '0;
			quo_q <= dividend;
		end else if (busy_q) begin
			if (fits) begin
				rem_q <= DIVISOR_W'(trial - {1'b0, dsr_q});
			end else begin
				rem_q <= trial[DIVISOR_W-1:0];
			end
			quo_q <= {quo_q[DIVIDEND_W-2:0], fits};
		end
	end

`ifndef ASSERT_OFF
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> busy_q && (cnt_q == '0))
		else $error("divider did not start");
`endif

endmodule

// ===== rtl/eps_datapath.sv =====
// ----------------------------------------------------------------------------
// eps_datapath
// Configuration registers, clamp and scale arithmetic, send state, ramp
// counter and the output register.
// ----------------------------------------------------------------------------
module eps_datapath #(
	parameter int SAMPLE_BITS = eps_pkg::SAMPLE_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wen,
	input  logic [eps_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [eps_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic [SAMPLE_BITS-1:0]              sample,
	input  eps_pkg::eps_cmd_t                   cmd,
	output eps_pkg::eps_sts_t                   sts,
	input  logic                                m_tready,
	output logic                                m_tvalid,
	output logic [eps_pkg::OUT_TDATA_W-1:0]     m_tdata,
	output logic                                m_tlast
);
	import eps_pkg::*;

	localparam int CMP_W = (SAMPLE_BITS > RANGE_W) ? SAMPLE_BITS : RANGE_W;

	logic [RANGE_W-1:0] range_low_q, range_high_q;
	logic [SCALE_W-1:0] scale_top_q, deadband_q;
	logic [CHAN_W-1:0]  midi_chan_q;
	logic [CCNUM_W-1:0] cc_number_q;

	logic [RANGE_W-1:0] offset_q, span_q;
	logic               empty_q;
	logic [PROD_W-1:0]  prod_q;
	logic [PROD_W-1:0]  quotient;
	logic               div_done;

	logic [SCALE_W-1:0] last_q, cur_q, target_q;
	logic               has_sent_q, up_q;

	logic               out_valid_q, out_last_q;
	logic [CCNUM_W-1:0] out_num_q;
	logic [SCALE_W-1:0] out_val_q;
	logic [OUTCH_W-1:0] out_chan_q;

	logic [CMP_W-1:0]   raw_ext, low_ext, high_ext;
	logic [RANGE_W-1:0] offset_d;
	logic [SCALE_W-1:0] value, diff;
	logic               rising;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			range_low_q  <= RST_RANGE_LOW;
			range_high_q <= RST_RANGE_HIGH;
			scale_top_q  <= RST_SCALE_TOP;
			deadband_q   <= RST_DEADBAND;
			midi_chan_q  <= RST_MIDI_CHAN;
			cc_number_q  <= RST_CC_NUMBER;
		end else if (cfg_wen) begin
			case (cfg_index)
				REG_RANGE_LOW:  range_low_q  <= cfg_data[RANGE_W-1:0];
				REG_RANGE_HIGH: range_high_q <= cfg_data[RANGE_W-1:0];
				REG_SCALE_TOP:  scale_top_q  <= cfg_data[SCALE_W-1:0];
				REG_DEADBAND:   deadband_q   <= cfg_data[SCALE_W-1:0];
				REG_MIDI_CHAN:  midi_chan_q  <= cfg_data[CHAN_W-1:0];
				REG_CC_NUMBER:  cc_number_q  <= cfg_data[CCNUM_W-1:0];
				default: ;
			endcase
		end
	end

	// Clamp to the window and take the offset from its low end.
	assign raw_ext  = CMP_W'(sample);
	assign low_ext  = CMP_W'(range_low_q);
	assign high_ext = CMP_W'(range_high_q);

	always_comb begin
		if (raw_ext < low_ext) begin
			offset_d = '0;
		end else if (raw_ext > high_ext) begin
			offset_d = range_high_q - range_low_q;
		end else begin
			offset_d = raw_ext[RANGE_W-1:0] - range_low_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			offset_q <= offset_d;
			span_q   <= range_high_q - range_low_q;
			empty_q  <= !(range_high_q > range_low_q);
		end
		if (cmd.mul) begin
			prod_q <= PROD_W'(offset_q) * PROD_W'(scale_top_q);
		end
	end

	eps_div #(
		.DIVIDEND_W(PROD_W),
		.DIVISOR_W (RANGE_W)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cmd.div_start),
		.dividend(prod_q),
		.divisor (span_q),
		.done    (div_done),
		.quotient(quotient)
	);

	// The quotient never exceeds scale_top, so its low bits are the value.
	assign value  = empty_q ? '0 : quotient[SCALE_W-1:0];
	assign rising = (value > last_q);
	assign diff   = rising ? (value - last_q) : (last_q - value);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q     <= '0;
			has_sent_q <= 1'b0;
		end else if (cmd.decide && !sts.skip) begin
			last_q     <= value;
			has_sent_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.decide && !sts.skip) begin
			target_q <= value;
			up_q     <= rising;
			if (!has_sent_q) begin
				cur_q <= value;
			end else if (rising) begin
				cur_q <= last_q + 1'b1;
			end else begin
				cur_q <= last_q - 1'b1;
			end
		end else if (cmd.emit) begin
			cur_q <= up_q ? (cur_q + 1'b1) : (cur_q - 1'b1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_num_q  <= cc_number_q;
			out_val_q  <= cur_q;
			out_chan_q <= OUTCH_W'(midi_chan_q) + 1'b1;
			out_last_q <= (cur_q == target_q);
		end
	end

	assign sts.div_done  = div_done;
	assign sts.skip      = has_sent_q && ((diff < deadband_q) || (value == last_q));
	assign sts.out_free  = !out_valid_q || m_tready;
	assign sts.at_target = (cur_q == target_q);

	assign m_tvalid = out_valid_q;
	assign m_tlast  = out_last_q;
	assign m_tdata  = OUT_TDATA_W'({out_chan_q, out_val_q, out_num_q});

`ifndef ASSERT_OFF
	a_first_single: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.decide && !has_sent_q) |=> (cur_q == target_q) && has_sent_q)
		else $error("first send does not form a single message");
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (!out_valid_q || m_tready))
		else $error("output register overwritten");
`endif

endmodule

// ===== rtl/eps_ctrl.sv =====
// ----------------------------------------------------------------------------
// eps_ctrl
// Sequencer of the scaler: capture, multiply, divide, decide, emit ramp.
// ----------------------------------------------------------------------------
module eps_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  eps_pkg::eps_sts_t sts,
	output eps_pkg::eps_cmd_t cmd
);
	import eps_pkg::*;

	typedef enum logic [5:0] {
		S_IDLE   = 6'b000001,
		S_MUL    = 6'b000010,
		S_LOAD   = 6'b000100,
		S_DIV    = 6'b001000,
		S_DECIDE = 6'b010000,
		S_EMIT   = 6'b100000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d       = state_q;
		cmd           = '0;
		s_tready      = 1'b0;
		case (state_q)
			S_IDLE: begin
				s_tready    = 1'b1;
				cmd.capture = s_tvalid;
				if (s_tvalid) begin
					state_d = S_MUL;
				end
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				state_d = S_LOAD;
			end
			S_LOAD: begin
				cmd.div_start = 1'b1;
				state_d       = S_DIV;
			end
			S_DIV: begin
				if (sts.div_done) begin
					state_d = S_DECIDE;
				end
			end
			S_DECIDE: begin
				cmd.decide = 1'b1;
				state_d    = sts.skip ? S_IDLE : S_EMIT;
			end
			S_EMIT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					if (sts.at_target) begin
						state_d = S_IDLE;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

`ifndef ASSERT_OFF
	a_emit_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> sts.out_free)
		else $error("emit issued while output register is held");
	a_div_to_decide: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV && sts.div_done) |=> (state_q == S_DECIDE))
		else $error("divide completion did not lead to decision");
	a_accept_to_mul: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> (state_q == S_MUL))
		else $error("accepted sample did not start processing");
`endif

endmodule
